[rtl/jfkc_pkg.sv]
// Shared types, marker codes and the frame kind decode for the JPEG
// frame kind classifier. No dependencies; compile first.
package jfkc_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_INVALID     = 2'd0;
   localparam kind_type KIND_BASELINE    = 2'd1;
   localparam kind_type KIND_PROGRESSIVE = 2'd2;
   localparam kind_type KIND_OTHER       = 2'd3;

   localparam logic [7:0] MARK_PREFIX = 8'hFF;
   localparam logic [7:0] MARK_SOI    = 8'hD8;
   localparam logic [7:0] MARK_EOI    = 8'hD9;
   localparam logic [7:0] MARK_RST0   = 8'hD0;
   localparam logic [7:0] MARK_RST7   = 8'hD7;
   localparam logic [7:0] MARK_SOS    = 8'hDA;
   localparam logic [7:0] MARK_SOF0   = 8'hC0;
   localparam logic [7:0] MARK_SOF1   = 8'hC1;
   localparam logic [7:0] MARK_SOF2   = 8'hC2;
   localparam logic [7:0] MARK_DHT    = 8'hC4;
   localparam logic [7:0] MARK_JPG    = 8'hC8;
   localparam logic [7:0] MARK_DAC    = 8'hCC;
   localparam logic [7:0] MARK_SOF15  = 8'hCF;

   // One result item headed for the output queue.
   typedef struct packed {
      logic     valid;
      kind_type kind;
   } result_type;

   typedef struct packed {
      logic     is_frame;
      kind_type kind;
   } frame_type;

   function automatic frame_type frame_kind(input logic [7:0] marker);
      frame_type fk;
      fk.is_frame = 1'b1;
      fk.kind     = KIND_OTHER;
      case (marker) inside
         MARK_SOF0:                     fk.kind = KIND_BASELINE;
         MARK_SOF2:                     fk.kind = KIND_PROGRESSIVE;
         MARK_DHT, MARK_JPG, MARK_DAC:  fk.is_frame = 1'b0;
         [MARK_SOF1:MARK_SOF15]:        fk.kind = KIND_OTHER;
         default:                       fk.is_frame = 1'b0;
      endcase
      return fk;
   endfunction

endpackage

[rtl/jfkc_if.sv]
// Valid/ready channel interfaces for the byte input and the kind result.
// Depends on jfkc_pkg.
interface jfkc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface jfkc_rsp_if import jfkc_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type kind;

   modport source (output valid, output kind, input ready);
   modport sink   (input valid, input kind, output ready);
endinterface

[rtl/jfkc_scanner.sv]
// Front end: marker segment scanner, one byte per accepted transfer.
// Depends on jfkc_pkg; feeds jfkc_queue with at most one result per byte.
module jfkc_scanner import jfkc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       final_byte,
   output result_type result
);

   localparam logic [2:0] PH_SOI0 = 3'd0;
   localparam logic [2:0] PH_SOI1 = 3'd1;
   localparam logic [2:0] PH_SCAN = 3'd2;
   localparam logic [2:0] PH_FILL = 3'd3;
   localparam logic [2:0] PH_LENH = 3'd4;
   localparam logic [2:0] PH_LENL = 3'd5;
   localparam logic [2:0] PH_SKIP = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  marker_ff, marker_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic        decided_ff, decided_in;

   logic        res_valid;
   kind_type    res_kind;
   logic        seg_done;
   logic [15:0] seg_len;
   logic [15:0] left_dec;
   frame_type   fk;

   assign seg_len  = {length_high_ff, data_byte};
   assign left_dec = bytes_left_ff - 16'd1;
   assign fk       = frame_kind(marker_ff);

   always_comb begin
      phase_in       = phase_ff;
      marker_in      = marker_ff;
      length_high_in = length_high_ff;
      bytes_left_in  = bytes_left_ff;
      decided_in     = decided_ff;
      res_valid      = 1'b0;
      res_kind       = KIND_INVALID;
      seg_done       = 1'b0;

      if (!decided_ff) begin
         unique case (phase_ff)
            PH_SOI0: begin
               if (data_byte == MARK_PREFIX) phase_in = PH_SOI1;
               else res_valid = 1'b1;
            end
            PH_SOI1: begin
               if (data_byte == MARK_SOI) phase_in = PH_SCAN;
               else res_valid = 1'b1;
            end
            PH_FILL: begin
               if (data_byte != MARK_PREFIX) begin
                  marker_in = data_byte;
                  unique case (data_byte) inside
                     [MARK_RST0:MARK_RST7], MARK_SOI, MARK_EOI: phase_in = PH_SCAN;
                     MARK_SOS: res_valid = 1'b1;
                     default:  phase_in = PH_LENH;
                  endcase
               end
            end
            PH_LENH: begin
               length_high_in = data_byte;
               phase_in       = PH_LENL;
            end
            PH_LENL: begin
               if (seg_len < 16'd2) begin
                  res_valid = 1'b1;
               end else begin
                  bytes_left_in = seg_len - 16'd2;
                  if (seg_len == 16'd2) seg_done = 1'b1;
                  else phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               bytes_left_in = left_dec;
               if (left_dec == 16'd0) seg_done = 1'b1;
            end
            default: begin
               phase_in = (data_byte == MARK_PREFIX) ? PH_FILL : PH_SCAN;
            end
         endcase

         // A completed segment either names the frame or sends us back to scanning.
         if (seg_done) begin
            if (fk.is_frame) begin
               res_valid = 1'b1;
               res_kind  = fk.kind;
            end else begin
               phase_in = PH_SCAN;
            end
         end
         if (res_valid) decided_in = 1'b1;
      end

      // Last byte: report invalid if still undecided, then rearm.
      if (final_byte) begin
         if (!decided_ff && !res_valid) begin
            res_valid = 1'b1;
            res_kind  = KIND_INVALID;
         end
         phase_in       = PH_SOI0;
         marker_in      = 8'd0;
         length_high_in = 8'd0;
         bytes_left_in  = 16'd0;
         decided_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SOI0;
         marker_ff      <= 8'd0;
         length_high_ff <= 8'd0;
         bytes_left_ff  <= 16'd0;
         decided_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         marker_ff      <= marker_in;
         length_high_ff <= length_high_in;
         bytes_left_ff  <= bytes_left_in;
         decided_ff     <= decided_in;
      end
   end

   assign result.valid = accept & res_valid;
   assign result.kind  = res_kind;

endmodule

[rtl/jfkc_queue.sv]
// Back end: short result queue that drives the response channel.
// Depends on jfkc_pkg; written by jfkc_scanner.
module jfkc_queue import jfkc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  result_type push,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output kind_type   out_kind
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   kind_type             slots_ff [DEPTH];
   logic [IDX_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_kind  = slots_ff[rd_ptr_ff];
   assign do_pop    = out_valid & out_ready;
   assign do_push   = push.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push.kind;
   end

endmodule

[rtl/jpeg_frame_kind_classifier_unit.sv]
// JPEG frame kind classifier: takes one file byte per ready cycle and reports the
// frame kind once per file. Depends on jfkc_pkg, jfkc_if, jfkc_scanner, jfkc_queue.
//
// Each accepted byte is handled in a single step: the scanner updates its phase,
// length and skip counter together, so a byte can be taken in every cycle in which
// the result queue is not full. A result is registered into that queue of
// QUEUE_DEPTH entries and reaches the response channel behind any older ones;
// req ready drops only while that queue is full. At most one kind is reported per
// file, and the byte flagged as last rearms the scanner for the next file.
module jpeg_frame_kind_classifier_unit import jfkc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   jfkc_req_if.sink      req_bus,
   jfkc_rsp_if.source    rsp_bus
);

   logic       req_accept;
   logic       queue_full;
   result_type scan_result;

   assign req_bus.ready = ~queue_full;
   assign req_accept    = req_bus.valid & req_bus.ready;

   jfkc_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .data_byte  (req_bus.data_byte),
      .final_byte (req_bus.final_byte),
      .result     (scan_result)
   );

   jfkc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (scan_result),
      .full      (queue_full),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_kind  (rsp_bus.kind)
   );

endmodule

[rtl/jfkc_checker.sv]
// Port-level checks for the JPEG frame kind classifier, bound to the top level.
// Depends on jfkc_pkg and jpeg_frame_kind_classifier_unit.
module jfkc_checker import jfkc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input kind_type   rsp_kind
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind))
      else $error("response kind changed while stalled");

   // Backpressure only comes from a full queue, so a result must be pending.
   a_stall_pending: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // No result appears without a byte transfer or an earlier pending result.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(req_valid && req_ready) && !$past(rsp_valid)
      |-> !rsp_valid)
      else $error("result appeared without a cause");

endmodule

bind jpeg_frame_kind_classifier_unit jfkc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_kind  (rsp_bus.kind)
);
